### rtl/core/rmsm_pkg.sv
// ----------------------------------------------------------------------------
// rmsm_pkg
// Shared types and constants for the windowed RMS level meter.
// ----------------------------------------------------------------------------
package rmsm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 32;
	localparam int SUM_W    = 47;
	localparam int CNT_W    = 16;
	localparam int LEVEL_W  = 16;
	localparam int BAR_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_STEP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_LIMIT     = 2'd2;

	localparam logic [CNT_W-1:0]   WINDOW_RESET    = 16'd1600;
	localparam logic [LEVEL_W-1:0] BAR_STEP_RESET  = 16'd100;
	localparam logic [BAR_W-1:0]   BAR_LIMIT_RESET = 8'd60;

	// mean < 2^31, so only the low 31 quotient bits are developed
	localparam int DIV_STEPS  = 31;
	localparam int ROOT_STEPS = 16;
	localparam int BAR_STEPS  = 16;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// shared subtract / compare unit width
	localparam int ALU_W = 19;

	typedef struct packed {
		logic                  start;
		logic                  take;
		logic [SUM_W-1:0]      sum;
		logic [CNT_W-1:0]      count;
		logic [LEVEL_W-1:0]    bar_step;
	} eng_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [LEVEL_W-1:0] rms;
		logic [LEVEL_W-1:0] bar_quot;
	} eng_rsp_t;

endpackage

### rtl/core/rmsm_alu.sv
// ----------------------------------------------------------------------------
// rmsm_alu
// Shared subtract and compare unit for divide and root iterations.
// ----------------------------------------------------------------------------
module rmsm_alu import rmsm_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] diff,
	output logic             ge
);

	logic [ALU_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[ALU_W-1:0];
	assign ge   = ~full[ALU_W];

endmodule

### rtl/core/rmsm_engine.sv
// ----------------------------------------------------------------------------
// rmsm_engine
// Sequencer for mean divide, floor square root and bar divide, one bit a cycle.
// ----------------------------------------------------------------------------
module rmsm_engine import rmsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  eng_req_t req,
	output eng_rsp_t rsp
);

	localparam logic [2:0] E_IDLE = 3'd0;
	localparam logic [2:0] E_DIV  = 3'd1;
	localparam logic [2:0] E_ROOT = 3'd2;
	localparam logic [2:0] E_BAR  = 3'd3;
	localparam logic [2:0] E_DONE = 3'd4;

	logic [2:0]         st_q;
	logic [STEP_W-1:0]  step_q;
	logic [16:0]        rem_q;
	logic [31:0]        sh_q;
	logic [LEVEL_W-1:0] root_q;
	logic [CNT_W-1:0]   div_q;

	logic [ALU_W-1:0]   alu_a;
	logic [ALU_W-1:0]   alu_b;
	logic [ALU_W-1:0]   alu_diff;
	logic               alu_ge;
	logic [16:0]        rem_next;
	logic [LEVEL_W-1:0] root_next;
	logic               last;

	always_comb begin
		unique case (st_q)
			E_ROOT: begin
				alu_a = {rem_q, sh_q[31:30]};
				alu_b = {1'b0, root_q, 2'b01};
			end
			E_BAR: begin
				alu_a = {2'b00, rem_q[15:0], sh_q[31]};
				alu_b = {3'b000, req.bar_step};
			end
			default: begin
				alu_a = {2'b00, rem_q[15:0], sh_q[31]};
				alu_b = {3'b000, div_q};
			end
		endcase
	end

	rmsm_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// partial remainder stays below 2^17 in every phase
	assign rem_next  = alu_ge ? alu_diff[16:0] : alu_a[16:0];
	assign root_next = {root_q[LEVEL_W-2:0], alu_ge};
	assign last      = (step_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			step_q <= '0;
		end else begin
			unique case (st_q)
				E_IDLE: begin
					if (req.start) begin
						st_q   <= E_DIV;
						step_q <= STEP_W'(DIV_STEPS - 1);
					end
				end
				E_DIV: begin
					if (last) begin
						st_q   <= E_ROOT;
						step_q <= STEP_W'(ROOT_STEPS - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				E_ROOT: begin
					if (last) begin
						st_q   <= E_BAR;
						step_q <= STEP_W'(BAR_STEPS - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				E_BAR: begin
					if (last) begin
						st_q <= E_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				E_DONE: begin
					if (req.take) begin
						st_q <= E_IDLE;
					end
				end
				default: begin
					st_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			E_IDLE: begin
				if (req.start) begin
					// top sum bits are already below the count: start mid-division
					rem_q  <= {1'b0, req.sum[SUM_W-1:DIV_STEPS]};
					sh_q   <= {req.sum[DIV_STEPS-1:0], 1'b0};
					div_q  <= req.count;
					root_q <= '0;
				end
			end
			E_DIV: begin
				sh_q <= {sh_q[30:0], alu_ge};
				if (last) begin
					rem_q <= '0;
				end else begin
					rem_q <= rem_next;
				end
			end
			E_ROOT: begin
				root_q <= root_next;
				if (last) begin
					rem_q <= '0;
					sh_q  <= {root_next, 16'h0000};
				end else begin
					rem_q <= rem_next;
					sh_q  <= {sh_q[29:0], 2'b00};
				end
			end
			E_BAR: begin
				rem_q <= rem_next;
				sh_q  <= {sh_q[30:0], alu_ge};
			end
			default: begin
			end
		endcase
	end

	assign rsp.busy     = (st_q != E_IDLE);
	assign rsp.done     = (st_q == E_DONE);
	assign rsp.rms      = root_q;
	assign rsp.bar_quot = sh_q[LEVEL_W-1:0];

endmodule

### rtl/core/windowed_rms_level_meter.sv
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// Sums squared PCM samples over a window and reports RMS level and bar length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample with in_valid / in_stall. An item that does not
//   close the window passes through take, square and accumulate; in_stall is
//   high while the square and accumulate states run for each accepted item.
//   When the count reaches window_length, the shared subtract unit runs
//   31 mean-divide steps, 16 root steps and 16 bar-divide steps before the
//   result is loaded into the output register, and no next item is taken
//   until then.
//   Output channel: rms_level, bar_length with out_valid / out_stall. One
//   output register holds the result; new items are taken while it waits.
//   If a new result is ready while the old one is still stalled, the
//   engine holds and in_stall stays high until the receiver takes the old one.
//   Config: cfg_wr_en, cfg_index, cfg_wdata; write only while idle.
//   Reset: window 1600, bar step 100, bar limit 60, sum and count cleared,
//   no result pending.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter import rmsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEVEL_W-1:0]    rms_level,
	output logic [BAR_W-1:0]      bar_length
);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_SQR  = 2'd1;
	localparam logic [1:0] T_ACC  = 2'd2;
	localparam logic [1:0] T_WAIT = 2'd3;

	logic [1:0]          st_q;
	logic [CNT_W-1:0]    window_q;
	logic [LEVEL_W-1:0]  bar_step_q;
	logic [BAR_W-1:0]    bar_limit_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic [SQ_W-1:0]     sq_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  rms_q;
	logic [BAR_W-1:0]    bar_q;

	logic [SAMPLE_W-1:0] mag;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    cnt_next;
	logic                hit;
	logic                accept;
	logic                slot_free;
	logic                take;
	logic [BAR_W-1:0]    bar_clamped;
	eng_req_t            eng_req;
	eng_rsp_t            eng_rsp;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (st_q != T_IDLE);
	// -32768 maps to 0x8000, which still fits unsigned
	assign mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
	assign sum_next  = sum_q + {{(SUM_W-SQ_W){1'b0}}, sq_q};
	assign cnt_next  = cnt_q + 1'b1;
	assign hit       = (cnt_next >= window_q);
	assign slot_free = !out_valid_q || !out_stall;
	assign take      = (st_q == T_WAIT) && eng_rsp.done && slot_free;

	assign eng_req.start    = (st_q == T_ACC) && hit;
	assign eng_req.take     = take;
	assign eng_req.sum      = sum_next;
	assign eng_req.count    = cnt_next;
	assign eng_req.bar_step = bar_step_q;

	rmsm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (eng_req),
		.rsp    (eng_rsp)
	);

	// zero bar step divides to all ones and clamps here
	assign bar_clamped = (eng_rsp.bar_quot > {{(LEVEL_W-BAR_W){1'b0}}, bar_limit_q}) ?
		bar_limit_q : eng_rsp.bar_quot[BAR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			bar_step_q  <= BAR_STEP_RESET;
			bar_limit_q <= BAR_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_q    <= cfg_wdata;
				REG_BAR_STEP:      bar_step_q  <= cfg_wdata;
				REG_BAR_LIMIT:     bar_limit_q <= cfg_wdata[BAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				T_IDLE: begin
					if (accept) begin
						st_q <= T_SQR;
					end
				end
				T_SQR: begin
					st_q <= T_ACC;
				end
				T_ACC: begin
					if (hit) begin
						sum_q <= '0;
						cnt_q <= '0;
						st_q  <= T_WAIT;
					end else begin
						sum_q <= sum_next;
						cnt_q <= cnt_next;
						st_q  <= T_IDLE;
					end
				end
				T_WAIT: begin
					if (take) begin
						st_q <= T_IDLE;
					end
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase

			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag;
		end
		if (st_q == T_SQR) begin
			sq_q <= mag_q * mag_q;
		end
		if (take) begin
			rms_q <= eng_rsp.rms;
			bar_q <= bar_clamped;
		end
	end

	assign out_valid  = out_valid_q;
	assign rms_level  = rms_q;
	assign bar_length = bar_q;

	// a full count always closes the window, so it is never stored
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != {CNT_W{1'b1}})
		else $error("sample count reached its top value");

	a_out_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == T_WAIT))
		else $error("result appeared without a finished window");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eng_req.start |=> eng_rsp.busy)
		else $error("engine did not start");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		eng_rsp.done |-> (st_q == T_WAIT))
		else $error("engine done outside wait");

endmodule
